### src/ctse_pkg.sv
// Shared types and codes for the calendar time-set editor.
package ctse_pkg;

  // Command codes
  localparam logic [2:0] CMD_IDLE   = 3'd0;
  localparam logic [2:0] CMD_MODE   = 3'd1;
  localparam logic [2:0] CMD_SELECT = 3'd2;
  localparam logic [2:0] CMD_INC    = 3'd3;
  localparam logic [2:0] CMD_DEC    = 3'd4;
  localparam logic [2:0] CMD_LOAD   = 3'd5;

  // Field select codes
  localparam logic [2:0] FLD_NONE   = 3'd0;
  localparam logic [2:0] FLD_YEAR   = 3'd1;
  localparam logic [2:0] FLD_MONTH  = 3'd2;
  localparam logic [2:0] FLD_DAY    = 3'd3;
  localparam logic [2:0] FLD_HOUR   = 3'd4;
  localparam logic [2:0] FLD_MINUTE = 3'd5;

  typedef struct packed {
    logic [6:0] year;
    logic [3:0] month;
    logic [4:0] day;
    logic [4:0] hour;
    logic [5:0] minute;
    logic [5:0] second;
  } cal_time_t;

  typedef struct packed {
    logic       mode;
    logic [2:0] sel;
    cal_time_t  tm;
  } cal_state_t;

  localparam cal_state_t STATE_RST = '{
    mode: 1'b0,
    sel:  FLD_NONE,
    tm:   '{year: 7'd0, month: 4'd1, day: 5'd1, hour: 5'd0, minute: 6'd0, second: 6'd0}
  };

endpackage

### src/ctse_step.sv
// Next-state logic for one editor command.
module ctse_step (
  input  ctse_pkg::cal_state_t cur,
  input  logic [2:0]           cmd,
  input  ctse_pkg::cal_time_t  load,
  output ctse_pkg::cal_state_t nxt,
  output logic                 wr
);

  function automatic logic [4:0] month_len(logic [3:0] month, logic [6:0] year);
    logic [4:0] len;
    if (month == 4'd4 || month == 4'd6 || month == 4'd9 || month == 4'd11) begin
      len = 5'd30;
    end else if (month == 4'd2) begin
      len = (year[1:0] == 2'b00) ? 5'd29 : 5'd28;
    end else begin
      len = 5'd31;
    end
    return len;
  endfunction

  function automatic logic [4:0] clamp_day(logic [4:0] day, logic [4:0] len);
    return (day > len) ? len : day;
  endfunction

  // (sel + 1) mod 6; the unused values 6 and 7 land on year and month
  function automatic logic [2:0] next_sel(logic [2:0] sel);
    logic [2:0] r;
    unique case (sel)
      ctse_pkg::FLD_NONE:   r = ctse_pkg::FLD_YEAR;
      ctse_pkg::FLD_YEAR:   r = ctse_pkg::FLD_MONTH;
      ctse_pkg::FLD_MONTH:  r = ctse_pkg::FLD_DAY;
      ctse_pkg::FLD_DAY:    r = ctse_pkg::FLD_HOUR;
      ctse_pkg::FLD_HOUR:   r = ctse_pkg::FLD_MINUTE;
      ctse_pkg::FLD_MINUTE: r = ctse_pkg::FLD_NONE;
      3'd6:                 r = ctse_pkg::FLD_YEAR;
      default:              r = ctse_pkg::FLD_MONTH;
    endcase
    return r;
  endfunction

  function automatic ctse_pkg::cal_time_t edit_field(logic [2:0] sel,
                                                     ctse_pkg::cal_time_t t,
                                                     logic up);
    ctse_pkg::cal_time_t r;
    logic [4:0]          len;
    r   = t;
    len = month_len(t.month, t.year);
    unique case (sel)
      ctse_pkg::FLD_YEAR: begin
        if (up) begin
          r.year = (t.year >= 7'd99) ? 7'd0 : t.year + 7'd1;
        end else begin
          r.year = (t.year == 7'd0 || t.year > 7'd99) ? 7'd99 : t.year - 7'd1;
        end
        r.day = clamp_day(t.day, month_len(t.month, r.year));
      end
      ctse_pkg::FLD_MONTH: begin
        if (up) begin
          r.month = (t.month >= 4'd12) ? 4'd1 : t.month + 4'd1;
        end else begin
          r.month = (t.month <= 4'd1 || t.month > 4'd12) ? 4'd12 : t.month - 4'd1;
        end
        r.day = clamp_day(t.day, month_len(r.month, t.year));
      end
      ctse_pkg::FLD_DAY: begin
        if (up) begin
          r.day = (t.day >= len) ? 5'd1 : t.day + 5'd1;
        end else begin
          r.day = (t.day <= 5'd1 || t.day > len) ? len : t.day - 5'd1;
        end
      end
      ctse_pkg::FLD_HOUR: begin
        if (up) begin
          r.hour = (t.hour >= 5'd23) ? 5'd0 : t.hour + 5'd1;
        end else begin
          r.hour = (t.hour == 5'd0 || t.hour > 5'd23) ? 5'd23 : t.hour - 5'd1;
        end
      end
      ctse_pkg::FLD_MINUTE: begin
        if (up) begin
          r.minute = (t.minute >= 6'd59) ? 6'd0 : t.minute + 6'd1;
        end else begin
          r.minute = (t.minute == 6'd0 || t.minute > 6'd59) ? 6'd59 : t.minute - 6'd1;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  always_comb begin
    nxt = cur;
    wr  = 1'b0;
    if (cmd == ctse_pkg::CMD_MODE) begin
      if (cur.mode) begin
        nxt.mode = 1'b0;
        nxt.sel  = ctse_pkg::FLD_NONE;
      end else begin
        nxt.mode = 1'b1;
      end
    end
    if (nxt.mode) begin
      unique case (cmd)
        ctse_pkg::CMD_SELECT: nxt.sel = next_sel(cur.sel);
        ctse_pkg::CMD_INC:    nxt.tm  = edit_field(cur.sel, cur.tm, 1'b1);
        ctse_pkg::CMD_DEC:    nxt.tm  = edit_field(cur.sel, cur.tm, 1'b0);
        default: ;
      endcase
      // every set-mode step zeroes seconds and requests a clock write
      nxt.tm.second = 6'd0;
      wr            = 1'b1;
    end else if (cmd == ctse_pkg::CMD_LOAD) begin
      nxt.tm = load;
    end
  end

endmodule

### src/calendar_time_set_editor_unit.sv
// Calendar time-set editor: input register, command step, state/result register.
// An accepted item waits in the input register; the step then writes state and result
// registers once the result slot is free or being emptied. Throughput: one item per cycle
// while results are taken; the input register takes a new item while a result waits.
// The result fields are the editor state itself, held until the result is taken.
// Reset (rst_n low, synchronous): state to show mode, no field, 00-01-01 00:00:00; stages empty.
module calendar_time_set_editor_unit (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [2:0] in_command,
  input  logic [6:0] in_load_year,
  input  logic [3:0] in_load_month,
  input  logic [4:0] in_load_day,
  input  logic [4:0] in_load_hour,
  input  logic [5:0] in_load_minute,
  input  logic [5:0] in_load_second,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       out_set_mode,
  output logic [2:0] out_selected_field,
  output logic [6:0] out_year_out,
  output logic [3:0] out_month_out,
  output logic [4:0] out_day_out,
  output logic [4:0] out_hour_out,
  output logic [5:0] out_minute_out,
  output logic [5:0] out_second_out,
  output logic       out_write_clock
);

  logic                 s1_valid_r, s1_valid_nxt;
  logic [2:0]           cmd_r;
  ctse_pkg::cal_time_t  load_r;
  logic                 out_valid_r, out_valid_nxt;
  ctse_pkg::cal_state_t state_r, state_nxt;
  logic                 wr_r, wr_nxt;
  logic                 advance;
  logic                 in_accept;

  // item moves into state/result when the result slot is free or being emptied
  assign advance   = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready  = !s1_valid_r || advance;
  assign in_accept = in_valid && in_ready;

  always_comb begin
    s1_valid_nxt  = in_accept ? 1'b1 : (advance ? 1'b0 : s1_valid_r);
    out_valid_nxt = advance ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);
  end

  ctse_step u_step (
    .cur  (state_r),
    .cmd  (cmd_r),
    .load (load_r),
    .nxt  (state_nxt),
    .wr   (wr_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      state_r     <= ctse_pkg::STATE_RST;
      wr_r        <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (advance) begin
        state_r <= state_nxt;
        wr_r    <= wr_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      cmd_r  <= in_command;
      load_r <= '{year: in_load_year, month: in_load_month, day: in_load_day,
                  hour: in_load_hour, minute: in_load_minute, second: in_load_second};
    end
  end

  assign out_valid          = out_valid_r;
  assign out_set_mode       = state_r.mode;
  assign out_selected_field = state_r.sel;
  assign out_year_out       = state_r.tm.year;
  assign out_month_out      = state_r.tm.month;
  assign out_day_out        = state_r.tm.day;
  assign out_hour_out       = state_r.tm.hour;
  assign out_minute_out     = state_r.tm.minute;
  assign out_second_out     = state_r.tm.second;
  assign out_write_clock    = wr_r;

`ifndef SYNTH
  a_show_no_field: assert property (@(posedge clk) disable iff (!rst_n)
    !state_r.mode |-> state_r.sel == ctse_pkg::FLD_NONE)
    else $error("field selected in show mode");

  a_set_writes: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && state_r.mode |-> state_r.tm.second == 6'd0 && wr_r)
    else $error("set-mode result without zero seconds and write strobe");

  a_show_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !state_r.mode |-> !wr_r)
    else $error("write strobe in show mode");

  a_state_holds: assert property (@(posedge clk) disable iff (!rst_n)
    rst_n && !advance |=> $stable(state_r) && $stable(wr_r))
    else $error("state changed without an item");
`endif

endmodule

### bench/calendar_time_set_editor_unit_test.sv
// Self-checking testbench for the calendar time-set editor: directed, stall and random traffic.
module calendar_time_set_editor_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  // Command values with no function of their own; the block treats them as idle
  localparam logic [2:0] CMD_RSVD_A = 3'd6;
  localparam logic [2:0] CMD_RSVD_B = 3'd7;

  localparam int STALL_LIMIT  = 1000;
  localparam int HOLD_CYCLES  = 40;
  localparam int RANDOM_UNTIL = 400;
  localparam int TOTAL_ITEMS  = 450;

  localparam ctse_pkg::cal_time_t READING_ONES = '{year: 7'h7F, month: 4'hF, day: 5'h1F,
                                                   hour: 5'h1F, minute: 6'h3F,
                                                   second: 6'h3F};
  localparam ctse_pkg::cal_time_t READING_ZERO = '0;

  typedef struct packed {
    logic                mode;
    logic [2:0]          sel;
    ctse_pkg::cal_time_t tm;
    logic                wr;
  } calendar_view_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [2:0] in_command = ctse_pkg::CMD_IDLE;
  logic [6:0] in_load_year = '0;
  logic [3:0] in_load_month = '0;
  logic [4:0] in_load_day = '0;
  logic [4:0] in_load_hour = '0;
  logic [5:0] in_load_minute = '0;
  logic [5:0] in_load_second = '0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic       out_set_mode;
  logic [2:0] out_selected_field;
  logic [6:0] out_year_out;
  logic [3:0] out_month_out;
  logic [4:0] out_day_out;
  logic [4:0] out_hour_out;
  logic [5:0] out_minute_out;
  logic [5:0] out_second_out;
  logic       out_write_clock;

  calendar_view_t       pending_views[$];
  ctse_pkg::cal_state_t calendar;

  bit calm = 1'b0;
  bit sender_gaps_on = 1'b1;
  int long_holds_asked = 0;
  int long_holds_done = 0;
  int idle_cycles = 0;
  int mismatches = 0;
  int items_sent = 0;
  int results_seen = 0;
  int set_steps = 0;
  int loads_taken = 0;
  int sessions = 0;

  calendar_time_set_editor_unit DUT (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_command         (in_command),
    .in_load_year       (in_load_year),
    .in_load_month      (in_load_month),
    .in_load_day        (in_load_day),
    .in_load_hour       (in_load_hour),
    .in_load_minute     (in_load_minute),
    .in_load_second     (in_load_second),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_set_mode       (out_set_mode),
    .out_selected_field (out_selected_field),
    .out_year_out       (out_year_out),
    .out_month_out      (out_month_out),
    .out_day_out        (out_day_out),
    .out_hour_out       (out_hour_out),
    .out_minute_out     (out_minute_out),
    .out_second_out     (out_second_out),
    .out_write_clock    (out_write_clock)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // ---------------- calendar predictor ----------------

  function automatic int month_days(ctse_pkg::cal_time_t t);
    case (t.month)
      4'd4, 4'd6, 4'd9, 4'd11: return 30;
      4'd2: return (t.year % 4 == 0) ? 29 : 28;
      default: return 31;
    endcase
  endfunction

  function automatic int wrap_up(int v, int lo, int hi);
    return (v >= hi) ? lo : v + 1;
  endfunction

  // out-of-range values (month or day 0 too) jump to the top
  function automatic int wrap_down(int v, int lo, int hi);
    return (v <= lo || v > hi) ? hi : v - 1;
  endfunction

  function automatic void clamp_day();
    int len;
    len = month_days(calendar.tm);
    if (calendar.tm.day > len) calendar.tm.day = 5'(len);
  endfunction

  function automatic void edit_field(bit up);
    int len;
    int v;
    len = month_days(calendar.tm);
    case (calendar.sel)
      ctse_pkg::FLD_YEAR: begin
        v = up ? wrap_up(calendar.tm.year, 0, 99) : wrap_down(calendar.tm.year, 0, 99);
        calendar.tm.year = 7'(v);
        clamp_day();
      end
      ctse_pkg::FLD_MONTH: begin
        v = up ? wrap_up(calendar.tm.month, 1, 12) : wrap_down(calendar.tm.month, 1, 12);
        calendar.tm.month = 4'(v);
        clamp_day();
      end
      ctse_pkg::FLD_DAY: begin
        v = up ? wrap_up(calendar.tm.day, 1, len) : wrap_down(calendar.tm.day, 1, len);
        calendar.tm.day = 5'(v);
      end
      ctse_pkg::FLD_HOUR: begin
        v = up ? wrap_up(calendar.tm.hour, 0, 23) : wrap_down(calendar.tm.hour, 0, 23);
        calendar.tm.hour = 5'(v);
      end
      ctse_pkg::FLD_MINUTE: begin
        v = up ? wrap_up(calendar.tm.minute, 0, 59) : wrap_down(calendar.tm.minute, 0, 59);
        calendar.tm.minute = 6'(v);
      end
      default: ;
    endcase
  endfunction

  function automatic calendar_view_t step_calendar(logic [2:0] cmd,
                                                   ctse_pkg::cal_time_t rd);
    calendar_view_t v;
    v.wr = 1'b0;
    if (cmd == ctse_pkg::CMD_MODE) begin
      if (calendar.mode) begin
        calendar.mode = 1'b0;
        calendar.sel = ctse_pkg::FLD_NONE;
      end else begin
        calendar.mode = 1'b1;
      end
    end
    if (calendar.mode) begin
      case (cmd)
        ctse_pkg::CMD_SELECT: calendar.sel = 3'((calendar.sel + 1) % 6);
        ctse_pkg::CMD_INC:    edit_field(1'b1);
        ctse_pkg::CMD_DEC:    edit_field(1'b0);
        default: ;
      endcase
      calendar.tm.second = '0;
      v.wr = 1'b1;
    end else if (cmd == ctse_pkg::CMD_LOAD) begin
      calendar.tm = rd;
    end
    v.mode = calendar.mode;
    v.sel = calendar.sel;
    v.tm = calendar.tm;
    return v;
  endfunction

  function automatic string view_text(calendar_view_t v);
    return $sformatf("mode=%0d sel=%0d %0d-%0d-%0d %0d:%0d:%0d wr=%0d", v.mode, v.sel,
                     v.tm.year, v.tm.month, v.tm.day, v.tm.hour, v.tm.minute,
                     v.tm.second, v.wr);
  endfunction

  // raw readings are random in every bit; otherwise in-range fields biased to their ends
  function automatic ctse_pkg::cal_time_t pick_reading(bit raw);
    ctse_pkg::cal_time_t r;
    if (raw) begin
      r.year = 7'($urandom);
      r.month = 4'($urandom);
      r.day = 5'($urandom);
      r.hour = 5'($urandom);
      r.minute = 6'($urandom);
      r.second = 6'($urandom);
    end else begin
      r.year = ($urandom_range(0, 3) == 0) ? ($urandom_range(0, 1) ? 7'd99 : 7'd0)
                                            : 7'($urandom_range(0, 99));
      r.month = ($urandom_range(0, 2) == 0) ? 4'd2 : 4'($urandom_range(1, 12));
      r.day = $urandom_range(0, 1) ? 5'($urandom_range(28, 31)) : 5'($urandom_range(1, 31));
      r.hour = ($urandom_range(0, 3) == 0) ? 5'd23 : 5'($urandom_range(0, 23));
      r.minute = ($urandom_range(0, 3) == 0) ? 6'd59 : 6'($urandom_range(0, 59));
      r.second = 6'($urandom_range(0, 59));
    end
    return r;
  endfunction

  // ---------------- driving ----------------

  // called right after a rising edge; returns at the edge taking the item or after a sender gap
  task automatic send_item(logic [2:0] cmd, ctse_pkg::cal_time_t rd);
    bit fire;
    calendar_view_t v;
    in_valid <= 1'b1;
    in_command <= cmd;
    in_load_year <= rd.year;
    in_load_month <= rd.month;
    in_load_day <= rd.day;
    in_load_hour <= rd.hour;
    in_load_minute <= rd.minute;
    in_load_second <= rd.second;
    do begin
      @(negedge clk);
      fire = in_ready;
      @(posedge clk);
    end while (!fire);
    v = step_calendar(cmd, rd);
    pending_views.push_back(v);
    items_sent++;
    if (v.wr) set_steps++;
    else if (cmd == ctse_pkg::CMD_LOAD) loads_taken++;
    if (!calm && sender_gaps_on && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_views.size() != 0) @(posedge clk);
  endtask

  // receiver: random stalls, long holds on request, always ready in the tail
  initial begin
    do @(posedge clk); while (rst_n !== 1'b1);
    forever begin
      @(posedge clk);
      if (long_holds_done < long_holds_asked) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        long_holds_done++;
        out_ready <= 1'b1;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 19)) @(posedge clk);
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // ---------------- checking ----------------

  // outputs only move at rising edges, so mid-cycle values hold at the next edge
  always @(negedge clk) begin : reading_monitor
    calendar_view_t got;
    calendar_view_t want;
    if (rst_n && out_valid && out_ready) begin
      got.mode = out_set_mode;
      got.sel = out_selected_field;
      got.tm.year = out_year_out;
      got.tm.month = out_month_out;
      got.tm.day = out_day_out;
      got.tm.hour = out_hour_out;
      got.tm.minute = out_minute_out;
      got.tm.second = out_second_out;
      got.wr = out_write_clock;
      if (pending_views.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected reading: %s", view_text(got));
      end else begin
        want = pending_views.pop_front();
        results_seen++;
        if (got.mode !== want.mode || got.sel !== want.sel ||
            got.tm.year !== want.tm.year || got.tm.month !== want.tm.month ||
            got.tm.day !== want.tm.day || got.tm.hour !== want.tm.hour ||
            got.tm.minute !== want.tm.minute || got.tm.second !== want.tm.second ||
            got.wr !== want.wr) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("mismatch on reading %0d", results_seen);
            $display("  expected %s", view_text(want));
            $display("  actual   %s", view_text(got));
          end
        end
      end
    end
  end

  always @(negedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("watchdog: no handshake for %0d cycles", STALL_LIMIT);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // ---------------- tests ----------------

  task automatic test_show_mode_keys();
    send_item(ctse_pkg::CMD_IDLE, pick_reading(1'b1));
    send_item(CMD_RSVD_B, pick_reading(1'b1));
    send_item(ctse_pkg::CMD_SELECT, pick_reading(1'b0));
    send_item(ctse_pkg::CMD_INC, pick_reading(1'b0));
    send_item(ctse_pkg::CMD_DEC, pick_reading(1'b0));
    send_item(ctse_pkg::CMD_LOAD, READING_ZERO);
    send_item(ctse_pkg::CMD_LOAD, READING_ONES);
  endtask

  // starts from the all-ones reading, so every field but the day begins above its range
  task automatic test_set_mode_wraps();
    send_item(ctse_pkg::CMD_MODE, READING_ZERO);
    send_item(ctse_pkg::CMD_DEC, READING_ONES);        // no field selected: nothing moves
    send_item(ctse_pkg::CMD_SELECT, READING_ZERO);
    send_item(ctse_pkg::CMD_INC, READING_ZERO);        // year above range wraps to 0
    send_item(ctse_pkg::CMD_SELECT, READING_ZERO);
    send_item(ctse_pkg::CMD_INC, READING_ZERO);        // month 15 -> 1
    send_item(ctse_pkg::CMD_INC, READING_ZERO);        // into February of a leap year
    send_item(ctse_pkg::CMD_SELECT, READING_ZERO);
    send_item(ctse_pkg::CMD_INC, READING_ZERO);
    send_item(ctse_pkg::CMD_DEC, READING_ZERO);
    send_item(ctse_pkg::CMD_SELECT, READING_ZERO);
    send_item(ctse_pkg::CMD_INC, READING_ZERO);
    send_item(ctse_pkg::CMD_DEC, READING_ZERO);
    send_item(ctse_pkg::CMD_SELECT, READING_ZERO);
    send_item(ctse_pkg::CMD_DEC, READING_ZERO);
    send_item(ctse_pkg::CMD_INC, READING_ZERO);
    send_item(ctse_pkg::CMD_SELECT, READING_ZERO);     // wraps back to no field
    send_item(ctse_pkg::CMD_LOAD, pick_reading(1'b0)); // ignored while setting
    send_item(ctse_pkg::CMD_MODE, READING_ONES);
  endtask

  task automatic test_output_stall();
    sender_gaps_on = 1'b0;
    long_holds_asked++;
    repeat (20) send_item(3'($urandom_range(0, 5)), pick_reading(1'b1));
    sender_gaps_on = 1'b1;
    drain_results();
    @(posedge clk);
  endtask

  task automatic run_edit_session();
    int pick;
    logic [2:0] cmd;
    sessions++;
    send_item(ctse_pkg::CMD_LOAD, pick_reading($urandom_range(0, 9) == 0));
    send_item(ctse_pkg::CMD_MODE, pick_reading(1'b1));
    repeat ($urandom_range(0, 5)) send_item(ctse_pkg::CMD_SELECT, pick_reading(1'b1));
    repeat ($urandom_range(1, 14)) begin
      pick = $urandom_range(0, 19);
      if (pick < 5) cmd = ctse_pkg::CMD_SELECT;
      else if (pick < 11) cmd = ctse_pkg::CMD_INC;
      else if (pick < 17) cmd = ctse_pkg::CMD_DEC;
      else if (pick == 17) cmd = ctse_pkg::CMD_LOAD;
      else if (pick == 18) cmd = ctse_pkg::CMD_IDLE;
      else cmd = CMD_RSVD_A;
      send_item(cmd, pick_reading(1'b1));
    end
    // now and then stay in set mode, so the next load is ignored
    if ($urandom_range(0, 9) != 0) send_item(ctse_pkg::CMD_MODE, pick_reading(1'b1));
  endtask

  task automatic test_random_sessions();
    while (items_sent < RANDOM_UNTIL) begin
      if ($urandom_range(0, 4) == 0) send_item(3'($urandom_range(0, 7)), pick_reading(1'b1));
      else run_edit_session();
    end
  endtask

  task automatic test_steady_stream();
    calm = 1'b1;
    while (items_sent < TOTAL_ITEMS) run_edit_session();
  endtask

  initial begin
    calendar = ctse_pkg::STATE_RST;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_show_mode_keys();
    test_set_mode_wraps();
    test_output_stall();
    test_random_sessions();
    test_steady_stream();

    drain_results();
    repeat (4) @(posedge clk);

    $display("Sent %0d commands: %0d set-mode steps, %0d show-mode loads, %0d edit sessions",
             items_sent, set_steps, loads_taken, sessions);
    $display("Checked %0d readings, including a %0d-cycle output hold and a full drain",
             results_seen, HOLD_CYCLES);
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
